// ===== rtl/core/csv_field_tokenizer_defines.svh =====
// assertion macros shared by the csv tokenizer rtl
// no dependencies; the assertions drop out when SYNTH is defined
`ifndef CSV_FIELD_TOKENIZER_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_DEFINES_SVH

`ifndef SYNTH
`define CSV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csv tokenizer assertion failed");
`define CSV_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("csv tokenizer forbidden condition");
`else
`define CSV_ASSERT(lbl, clk, rst_n, prop)
`define CSV_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/core/csv_tok_pkg.sv =====
// types and constants for the csv field tokenizer
// no dependencies; used by every rtl file of the block
package csv_tok_pkg;

    localparam logic [7:0] QUOTE_BYTE   = 8'h22;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] DELIM_RESET  = 8'h2C;

    localparam logic CMD_TEXT  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_EMPTY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_QUOTED = 2'd2,
        MODE_QSEEN  = 2'd3
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       last_of_run;
    } result_t;

    // up to two results come out of one step
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_t;

endpackage

// ===== rtl/core/csv_tok_if.sv =====
// handshake interfaces for the csv field tokenizer channels
// depends on csv_tok_pkg
interface csv_tok_in_if
    import csv_tok_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] text_byte;

    modport source (output valid, output cmd, output text_byte, input ready);
    modport sink (input valid, input cmd, input text_byte, output ready);
endinterface

interface csv_tok_out_if
    import csv_tok_pkg::*;
();
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] data_byte;
    logic       last_of_run;

    modport source (output valid, output kind, output data_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input kind, input data_byte, input last_of_run,
                  output ready);
endinterface

interface csv_tok_cfg_if
    import csv_tok_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] delimiter_char;

    modport source (output valid, output delimiter_char, input ready);
    modport sink (input valid, input delimiter_char, output ready);
endinterface

// ===== rtl/core/csv_tok_parser.sv =====
// parse state machine: one byte in, up to two results out per step
// depends on csv_tok_pkg and the assertion macros
`include "csv_field_tokenizer_defines.svh"

module csv_tok_parser
    import csv_tok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic       cmd,
    input  logic [7:0] text_byte,
    input  logic [7:0] delimiter_char,
    output step_t      res
);

    mode_t mode_reg;
    mode_t mode_next;
    logic  record_open_reg;
    logic  record_open_next;
    logic  is_delim;
    logic  is_quote;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_START;
            record_open_reg <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            record_open_reg <= record_open_next;
        end
    end

    assign is_delim = (text_byte == delimiter_char);
    assign is_quote = (text_byte == QUOTE_BYTE);

    always_comb
    begin
        mode_next        = mode_reg;
        record_open_next = record_open_reg;
        res.count        = 2'd0;
        res.res0         = '{kind: KIND_DATA, data_byte: 8'h00, last_of_run: 1'b0};
        res.res1         = '{kind: KIND_DATA, data_byte: 8'h00, last_of_run: 1'b0};

        if (cmd == CMD_FLUSH)
        begin
            if (record_open_reg || mode_reg != MODE_START)
            begin
                res.count     = 2'd1;
                res.res0.kind = KIND_RECORD;
            end
            mode_next        = MODE_START;
            record_open_next = 1'b0;
        end
        else if (text_byte == NEWLINE_BYTE)
        begin
            res.count = 2'd1;
            if (mode_reg == MODE_START && !record_open_reg)
                res.res0.kind = KIND_EMPTY;
            else
                res.res0.kind = KIND_RECORD;
            mode_next        = MODE_START;
            record_open_next = 1'b0;
        end
        else
        begin
            record_open_next = 1'b1;
            unique case (mode_reg)
                MODE_START:
                begin
                    if (is_delim)
                    begin
                        res.count     = 2'd1;
                        res.res0.kind = KIND_FIELD;
                    end
                    else if (is_quote)
                        mode_next = MODE_QUOTED;
                    else
                    begin
                        res.count          = 2'd1;
                        res.res0.data_byte = text_byte;
                        mode_next          = MODE_PLAIN;
                    end
                end
                MODE_PLAIN:
                begin
                    res.count = 2'd1;
                    if (is_delim)
                    begin
                        res.res0.kind = KIND_FIELD;
                        mode_next     = MODE_START;
                    end
                    else
                        res.res0.data_byte = text_byte;
                end
                MODE_QUOTED:
                begin
                    if (is_quote)
                        mode_next = MODE_QSEEN;
                    else
                    begin
                        res.count          = 2'd1;
                        res.res0.data_byte = text_byte;
                    end
                end
                MODE_QSEEN:
                begin
                    if (is_quote)
                    begin
                        // doubled quote collapses to one
                        res.count          = 2'd1;
                        res.res0.data_byte = QUOTE_BYTE;
                        mode_next          = MODE_QUOTED;
                    end
                    else if (is_delim)
                    begin
                        res.count     = 2'd1;
                        res.res0.kind = KIND_FIELD;
                        mode_next     = MODE_START;
                    end
                    else
                    begin
                        // lone quote is kept, field stays quoted
                        res.count          = 2'd2;
                        res.res0.data_byte = QUOTE_BYTE;
                        res.res1.data_byte = text_byte;
                        mode_next          = MODE_QUOTED;
                    end
                end
                default:
                    mode_next = MODE_START;
            endcase
        end

        if (res.count == 2'd1)
            res.res0.last_of_run = 1'b1;
        else if (res.count == 2'd2)
            res.res1.last_of_run = 1'b1;
    end

    `CSV_ASSERT(a_pair_only_after_quote, clk, rst_n, step_en && res.count == 2'd2 |-> mode_reg == MODE_QSEEN)
    `CSV_ASSERT(a_flush_clears_state, clk, rst_n, step_en && cmd == CMD_FLUSH |=> mode_reg == MODE_START && !record_open_reg)
    `CSV_ASSERT(a_quoted_implies_open, clk, rst_n, mode_reg != MODE_START |-> record_open_reg)

endmodule

// ===== rtl/core/csv_tok_outq.sv =====
// small result queue: takes up to two results a cycle, gives one
// depends on csv_tok_pkg, csv_tok_if and the assertion macros
`include "csv_field_tokenizer_defines.svh"

module csv_tok_outq
    import csv_tok_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_en,
    input  step_t               push,
    output logic                room,
    csv_tok_out_if.source       tok_out
);

    result_t              entry_reg [Q_DEPTH];
    logic [Q_IDX_W-1:0]   wr_ptr_reg;
    logic [Q_IDX_W-1:0]   wr_ptr_next;
    logic [Q_IDX_W-1:0]   rd_ptr_reg;
    logic [Q_IDX_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic [Q_CNT_W-1:0]   cnt_next;
    logic [1:0]           push_cnt;
    logic                 pop;

    assign push_cnt = push_en ? push.count : 2'd0;
    assign pop      = tok_out.valid && tok_out.ready;
    // space for a full step of two results
    assign room     = (cnt_reg <= Q_CNT_W'(Q_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_IDX_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + Q_IDX_W'(pop);
        cnt_next    = cnt_reg + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            entry_reg[wr_ptr_reg] <= push.res0;
        if (push_cnt == 2'd2)
            entry_reg[wr_ptr_reg + Q_IDX_W'(1)] <= push.res1;
    end

    assign tok_out.valid       = (cnt_reg != '0);
    assign tok_out.kind        = entry_reg[rd_ptr_reg].kind;
    assign tok_out.data_byte   = entry_reg[rd_ptr_reg].data_byte;
    assign tok_out.last_of_run = entry_reg[rd_ptr_reg].last_of_run;

    `CSV_ASSERT_NEVER(a_cnt_in_range, clk, rst_n, cnt_reg > Q_CNT_W'(Q_DEPTH))
    `CSV_ASSERT_NEVER(a_push_fits, clk, rst_n, push_en && !room)
    `CSV_ASSERT(a_ptr_gap, clk, rst_n, cnt_reg == '0 || cnt_reg == Q_CNT_W'(Q_DEPTH) |-> wr_ptr_reg == rd_ptr_reg)

endmodule

// ===== rtl/core/csv_field_tokenizer.sv =====
// csv field tokenizer: splits a byte stream of csv text into field bytes and end marks
// depends on csv_tok_pkg, csv_tok_if, csv_tok_parser and csv_tok_outq
//
// text_in carries one command per transfer: a text byte (cmd 0) or an end-of-text
// flush (cmd 1). tok_out gives the results: data bytes, field end, field and record
// end, empty record; last_of_run marks the final result of one input transfer.
// cfg sets the delimiter byte (comma after reset); it is always ready. cfg should be
// written only while the block is idle; the block itself does not enforce this.
// an input transfer lands in an input register; the parse step then runs once the
// queue has room and pushes its results into a four entry queue, from whose
// registered entries tok_out is driven.
// one input is taken every cycle while the queue has room; a quote followed by an
// ordinary byte inside a quoted field gives two results, and tok_out moves one
// result per cycle, so a run of such pairs drains at one result per cycle.
// the step stalls while the queue has fewer than two free entries; a stalled
// receiver therefore holds text_in ready low after the input register fills.
// reset clears the parse state, the queue and restores the comma delimiter.
module csv_field_tokenizer
    import csv_tok_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    csv_tok_in_if.sink     text_in,
    csv_tok_out_if.source  tok_out,
    csv_tok_cfg_if.sink    cfg
);

    logic       in_vld_reg;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] delim_reg;
    logic       step_fire;
    logic       room;
    step_t      step_res;

    assign step_fire     = in_vld_reg && room;
    assign text_in.ready = !in_vld_reg || step_fire;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            delim_reg  <= DELIM_RESET;
        end
        else
        begin
            if (text_in.ready)
                in_vld_reg <= text_in.valid;
            if (cfg.valid)
                delim_reg <= cfg.delimiter_char;
        end
    end

    // payload only moves on an input transfer
    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            in_cmd_reg  <= text_in.cmd;
            in_byte_reg <= text_in.text_byte;
        end
    end

    csv_tok_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_fire),
        .cmd            (in_cmd_reg),
        .text_byte      (in_byte_reg),
        .delimiter_char (delim_reg),
        .res            (step_res)
    );

    csv_tok_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (step_fire),
        .push    (step_res),
        .room    (room),
        .tok_out (tok_out)
    );

endmodule
